FILE: hw/rtl/dset_pkg.sv
// shared types and constants of the day schedule event table
// used by dset_ctrl, dset_dp and day_schedule_event_table
`default_nettype none

package dset_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int DATA_W = 32;
	localparam int TIME_W = 11;
	localparam int MIN_PER_HOUR = 60;

	// request modes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ADD = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_LIST = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_FAIL = 3'd4;

	// datapath operations
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_SCAN = 4'd2;
	localparam logic [3:0] OP_EMIT = 4'd3;
	localparam logic [3:0] OP_TICK_PEND = 4'd4;
	localparam logic [3:0] OP_TICK_T1 = 4'd5;
	localparam logic [3:0] OP_TICK_T2 = 4'd6;
	localparam logic [3:0] OP_ADD_W1 = 4'd7;
	localparam logic [3:0] OP_ADD_W2 = 4'd8;
	localparam logic [3:0] OP_REMOVE = 4'd9;
	localparam logic [3:0] OP_LIST = 4'd10;

	typedef struct packed {
		logic [3:0] op;
		logic [IDX_W-1:0] idx;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic pend_valid;
		logic near_found;
		logic near_dup;
		logic near_le;
		logic hit_found;
		logic list_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dset_dp.sv
// datapath: slot table, scan accumulators, pending pointer, output register
// depends on dset_pkg
`default_nettype none

module dset_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire dset_pkg::cmd_t cmd,
	output dset_pkg::stat_t stat,
	input wire logic [4:0] hour,
	input wire logic [5:0] minute,
	input wire logic [31:0] entry_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [4:0] out_hour,
	output logic [5:0] out_minute,
	output logic [31:0] out_data,
	output logic last
);

	localparam int IW = dset_pkg::IDX_W;
	localparam int CW = dset_pkg::CNT_W;
	localparam int TW = dset_pkg::TIME_W;
	localparam int DW = dset_pkg::DATA_W;

	// slot table
	logic used_q [dset_pkg::ENTRIES];
	logic [4:0] hour_q [dset_pkg::ENTRIES];
	logic [5:0] minute_q [dset_pkg::ENTRIES];
	logic [DW-1:0] payload_q [dset_pkg::ENTRIES];
	logic [IW-1:0] next_q [dset_pkg::ENTRIES];
	logic [IW-1:0] prev_q [dset_pkg::ENTRIES];

	// request and control state
	logic [4:0] req_hour_q;
	logic [5:0] req_minute_q;
	logic [DW-1:0] req_data_q;
	logic [TW-1:0] t_q;
	logic [CW-1:0] count_q;
	logic pvalid_q;
	logic [IW-1:0] pslot_q;

	// scan accumulators
	logic near_found_q;
	logic [IW-1:0] best_q;
	logic [TW-1:0] bdist_q;
	logic [TW-1:0] btime_q;
	logic free_found_q;
	logic [IW-1:0] free_q;
	logic hit_found_q;
	logic [IW-1:0] hit_q;
	logic lfound_q;
	logic [IW-1:0] lbest_q;
	logic [TW-1:0] ltime_q;
	logic list_first_q;
	logic [TW-1:0] last_t_q;
	logic [CW-1:0] emitted_q;
	logic [IW-1:0] nb_q;

	logic out_valid_q;
	logic [2:0] status_q;
	logic [4:0] out_hour_q;
	logic [5:0] out_minute_q;
	logic [DW-1:0] out_data_q;
	logic last_q;

	logic [IW-1:0] rd_addr;
	logic [TW-1:0] rd_time;
	logic [TW-1:0] t_dist;
	logic first;
	logic near_take, free_take, hit_take, list_take;
	logic after;
	logic [IW-1:0] nb;
	logic emit;
	logic [2:0] e_status;
	logic [4:0] e_hour;
	logic [5:0] e_minute;
	logic [DW-1:0] e_data;
	logic e_last;
	logic [TW-1:0] in_time;

	// single read address per cycle, chosen by the operation
	always_comb begin
		case (cmd.op)
			dset_pkg::OP_SCAN: rd_addr = cmd.idx;
			dset_pkg::OP_TICK_PEND: rd_addr = pslot_q;
			dset_pkg::OP_TICK_T2: rd_addr = nb_q;
			dset_pkg::OP_REMOVE: rd_addr = hit_q;
			dset_pkg::OP_LIST: rd_addr = lbest_q;
			default: rd_addr = best_q;
		endcase
	end

	assign rd_time = TW'(hour_q[rd_addr]) * TW'(dset_pkg::MIN_PER_HOUR)
		+ TW'(minute_q[rd_addr]);
	assign in_time = TW'(hour) * TW'(dset_pkg::MIN_PER_HOUR) + TW'(minute);
	assign t_dist = (t_q >= rd_time) ? (t_q - rd_time) : (rd_time - t_q);
	assign first = (cmd.idx == '0);

	// scan candidate tests, earlier results ignored on the first slot
	assign near_take = used_q[rd_addr] && (first || !near_found_q || t_dist <= bdist_q);
	assign free_take = !used_q[rd_addr] && (first || !free_found_q);
	assign hit_take = used_q[rd_addr] && (rd_time == t_q) && (first || !hit_found_q);
	assign list_take = used_q[rd_addr] && (list_first_q || rd_time > last_t_q)
		&& (first || !lfound_q || rd_time < ltime_q);

	assign after = t_q > btime_q;
	assign nb = after ? next_q[best_q] : prev_q[best_q];

	// result selection
	always_comb begin
		emit = 1'b0;
		e_status = cmd.status;
		e_hour = '0;
		e_minute = '0;
		e_data = '0;
		e_last = 1'b1;
		case (cmd.op)
			dset_pkg::OP_EMIT: begin
				emit = 1'b1;
			end
			dset_pkg::OP_TICK_PEND: begin
				emit = 1'b1;
				if (rd_time == t_q) begin
					e_status = dset_pkg::ST_OK;
					e_data = payload_q[rd_addr];
				end else begin
					e_status = dset_pkg::ST_EMPTY;
				end
			end
			dset_pkg::OP_TICK_T1: begin
				emit = (t_q >= btime_q);
				e_status = dset_pkg::ST_OK;
				e_data = payload_q[rd_addr];
			end
			dset_pkg::OP_TICK_T2: begin
				emit = 1'b1;
				e_status = dset_pkg::ST_OK;
				e_data = payload_q[rd_addr];
			end
			dset_pkg::OP_ADD_W2, dset_pkg::OP_REMOVE: begin
				emit = 1'b1;
				e_status = dset_pkg::ST_OK;
			end
			dset_pkg::OP_LIST: begin
				emit = 1'b1;
				e_status = dset_pkg::ST_OK;
				e_hour = hour_q[rd_addr];
				e_minute = minute_q[rd_addr];
				e_data = payload_q[rd_addr];
				e_last = stat.list_last;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// table contents, no reset needed
	always_ff @(posedge clk) begin
		case (cmd.op)
			dset_pkg::OP_ADD_W1: begin
				hour_q[free_q] <= req_hour_q;
				minute_q[free_q] <= req_minute_q;
				payload_q[free_q] <= req_data_q;
				if (!near_found_q) begin
					next_q[free_q] <= free_q;
					prev_q[free_q] <= free_q;
				end else if (after) begin
					next_q[free_q] <= nb;
					prev_q[free_q] <= best_q;
				end else begin
					next_q[free_q] <= best_q;
					prev_q[free_q] <= nb;
				end
			end
			dset_pkg::OP_ADD_W2: begin
				if (near_found_q) begin
					if (after) begin
						prev_q[nb_q] <= free_q;
						next_q[best_q] <= free_q;
					end else begin
						next_q[nb_q] <= free_q;
						prev_q[best_q] <= free_q;
					end
				end
			end
			dset_pkg::OP_REMOVE: begin
				next_q[prev_q[rd_addr]] <= next_q[rd_addr];
				prev_q[next_q[rd_addr]] <= prev_q[rd_addr];
			end
			default: begin
			end
		endcase
	end

	// request capture and scan accumulators
	always_ff @(posedge clk) begin
		case (cmd.op)
			dset_pkg::OP_LOAD: begin
				req_hour_q <= hour;
				req_minute_q <= minute;
				req_data_q <= entry_data;
				t_q <= in_time;
				list_first_q <= 1'b1;
				emitted_q <= '0;
			end
			dset_pkg::OP_SCAN: begin
				// found flags restart on the first slot
				near_found_q <= near_take || (!first && near_found_q);
				free_found_q <= free_take || (!first && free_found_q);
				hit_found_q <= hit_take || (!first && hit_found_q);
				lfound_q <= list_take || (!first && lfound_q);
				if (near_take) begin
					best_q <= rd_addr;
					bdist_q <= t_dist;
					btime_q <= rd_time;
				end
				if (free_take) begin
					free_q <= rd_addr;
				end
				if (hit_take) begin
					hit_q <= rd_addr;
				end
				if (list_take) begin
					lbest_q <= rd_addr;
					ltime_q <= rd_time;
				end
			end
			dset_pkg::OP_TICK_T1: begin
				nb_q <= prev_q[best_q];
			end
			dset_pkg::OP_ADD_W1: begin
				nb_q <= nb;
			end
			dset_pkg::OP_LIST: begin
				list_first_q <= 1'b0;
				last_t_q <= rd_time;
				emitted_q <= emitted_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// control state: used flags, count, pending pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dset_pkg::ENTRIES; i++) begin
				used_q[i] <= 1'b0;
			end
			count_q <= '0;
			pvalid_q <= 1'b0;
			pslot_q <= '0;
		end else begin
			case (cmd.op)
				dset_pkg::OP_TICK_PEND: begin
					if (rd_time == t_q) begin
						pslot_q <= next_q[rd_addr];
					end
				end
				dset_pkg::OP_TICK_T1: begin
					if (t_q >= btime_q) begin
						pslot_q <= next_q[best_q];
						pvalid_q <= 1'b1;
					end
				end
				dset_pkg::OP_TICK_T2: begin
					pslot_q <= best_q;
					pvalid_q <= 1'b1;
				end
				dset_pkg::OP_ADD_W1: begin
					used_q[free_q] <= 1'b1;
					count_q <= count_q + CW'(1);
				end
				dset_pkg::OP_REMOVE: begin
					used_q[rd_addr] <= 1'b0;
					count_q <= count_q - CW'(1);
					if (count_q == CW'(1)) begin
						pvalid_q <= 1'b0;
						pslot_q <= '0;
					end else if (pvalid_q && pslot_q == rd_addr) begin
						pslot_q <= next_q[rd_addr];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= e_status;
			out_hour_q <= e_hour;
			out_minute_q <= e_minute;
			out_data_q <= e_data;
			last_q <= e_last;
		end
	end

	// status toward the controller
	assign stat.count_zero = (count_q == '0);
	assign stat.full = (count_q >= CW'(dset_pkg::ENTRIES));
	assign stat.pend_valid = pvalid_q;
	assign stat.near_found = near_found_q;
	assign stat.near_dup = (t_q == btime_q);
	assign stat.near_le = (t_q >= btime_q);
	assign stat.hit_found = hit_found_q;
	assign stat.list_last = (count_q == emitted_q + CW'(1));
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_hour = out_hour_q;
	assign out_minute = out_minute_q;
	assign out_data = out_data_q;
	assign last = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dset_ctrl.sv
// controller state machine: sequences scan, decision and update steps
// depends on dset_pkg
`default_nettype none

module dset_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire dset_pkg::stat_t stat,
	output dset_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_EMIT = 4'd3;
	localparam logic [3:0] S_TICK_PEND = 4'd4;
	localparam logic [3:0] S_TICK_T1 = 4'd5;
	localparam logic [3:0] S_TICK_T2 = 4'd6;
	localparam logic [3:0] S_ADD_W1 = 4'd7;
	localparam logic [3:0] S_ADD_W2 = 4'd8;
	localparam logic [3:0] S_REMOVE = 4'd9;
	localparam logic [3:0] S_LIST = 4'd10;

	logic [3:0] state_q, state_d;
	logic [dset_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [1:0] mode_q;
	logic [2:0] st_q, st_d;
	logic accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	// next state and command
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		st_d = st_q;
		cmd.op = dset_pkg::OP_NONE;
		cmd.idx = idx_q;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op = dset_pkg::OP_LOAD;
					idx_d = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.op = dset_pkg::OP_SCAN;
				idx_d = idx_q + dset_pkg::IDX_W'(1);
				if (idx_q == dset_pkg::IDX_W'(dset_pkg::ENTRIES - 1)) begin
					idx_d = '0;
					state_d = (mode_q == dset_pkg::MODE_LIST && !stat.count_zero)
						? S_LIST : S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_EMIT;
				case (mode_q)
					dset_pkg::MODE_TICK: begin
						if (stat.count_zero) begin
							st_d = dset_pkg::ST_EMPTY;
						end else if (stat.pend_valid) begin
							state_d = S_TICK_PEND;
						end else begin
							state_d = S_TICK_T1;
						end
					end
					dset_pkg::MODE_ADD: begin
						if (stat.full) begin
							st_d = dset_pkg::ST_OVERFLOW;
						end else if (stat.near_found && stat.near_dup) begin
							st_d = dset_pkg::ST_FAIL;
						end else begin
							state_d = S_ADD_W1;
						end
					end
					dset_pkg::MODE_REMOVE: begin
						if (stat.count_zero) begin
							st_d = dset_pkg::ST_UNDERFLOW;
						end else if (!stat.hit_found) begin
							st_d = dset_pkg::ST_FAIL;
						end else begin
							state_d = S_REMOVE;
						end
					end
					default: begin
						st_d = dset_pkg::ST_FAIL;
					end
				endcase
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_EMIT;
					state_d = S_IDLE;
				end
			end
			S_TICK_PEND: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_TICK_PEND;
					state_d = S_IDLE;
				end
			end
			S_TICK_T1: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_TICK_T1;
					state_d = stat.near_le ? S_IDLE : S_TICK_T2;
				end
			end
			S_TICK_T2: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_TICK_T2;
					state_d = S_IDLE;
				end
			end
			S_ADD_W1: begin
				cmd.op = dset_pkg::OP_ADD_W1;
				state_d = S_ADD_W2;
			end
			S_ADD_W2: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_ADD_W2;
					state_d = S_IDLE;
				end
			end
			S_REMOVE: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_REMOVE;
					state_d = S_IDLE;
				end
			end
			S_LIST: begin
				if (stat.out_free) begin
					cmd.op = dset_pkg::OP_LIST;
					state_d = stat.list_last ? S_IDLE : S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			mode_q <= dset_pkg::MODE_TICK;
			st_q <= dset_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			st_q <= st_d;
			if (accept) begin
				mode_q <= mode;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/day_schedule_event_table.sv
// Day schedule event table: 16 timed entries kept in a circular linked list.
// A request (mode, hour, minute, entry_data) enters on in_valid/in_ready.
// Mode tick fires the pending entry's payload, add inserts an entry, remove
// unlinks one, and list returns every entry in time order, one result each.
// Results leave on out_valid/out_ready; last marks the final result of a
// request. Each request starts with a scan of all 16 slots, one slot a cycle,
// followed by a decision state and the update or result states; a list
// request on a non-empty table skips the decision and scans all slots again
// before each entry it returns, and the next request is taken once the
// controller is back in idle. The slot scan goes through the single read port.
// Only one request is worked on at a time; in_ready is high while the block
// is idle, and a finished result may still sit in the output register while
// the next request is taken. When the receiver stalls, the controller holds
// before writing the next result and nothing is dropped.
// Reset empties the table and clears the pending entry; slot contents are
// left as they are and are never read before being written.
// depends on dset_pkg, dset_ctrl, dset_dp
`default_nettype none

module day_schedule_event_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire logic [4:0] hour,
	input wire logic [5:0] minute,
	input wire logic [31:0] entry_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [4:0] out_hour,
	output logic [5:0] out_minute,
	output logic [31:0] out_data,
	output logic last
);

	dset_pkg::cmd_t cmd;
	dset_pkg::stat_t stat;

	dset_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.stat(stat),
		.cmd(cmd)
	);

	dset_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.hour(hour),
		.minute(minute),
		.entry_data(entry_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_data(out_data),
		.last(last)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_day_schedule_event_table.sv
// testbench of day_schedule_event_table: directed table, fill to capacity, then random requests,
// every result checked against a behavioral model of the schedule table
// depends on dset_pkg and day_schedule_event_table
`timescale 1ns / 1ps

module tb_day_schedule_event_table;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_REQUESTS = 180;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [31:0] data;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [31:0] data;
		logic fixed;
		logic [2:0] fixed_status;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = dset_pkg::MODE_TICK;
	logic [4:0] hour = '0;
	logic [5:0] minute = '0;
	logic [31:0] entry_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [4:0] out_hour;
	logic [5:0] out_minute;
	logic [31:0] out_data;
	logic last;

	// schedule model state
	logic sched_used [dset_pkg::ENTRIES];
	logic [4:0] sched_hour [dset_pkg::ENTRIES];
	logic [5:0] sched_minute [dset_pkg::ENTRIES];
	logic [31:0] sched_data [dset_pkg::ENTRIES];
	logic [3:0] sched_next [dset_pkg::ENTRIES];
	logic [3:0] sched_prev [dset_pkg::ENTRIES];
	int sched_count;
	logic pend_valid;
	logic [3:0] pend_slot;

	result_t expected_results [$];
	int errors = 0;
	int idle_cycles = 0;
	bit fixed_pending = 0;
	logic [2:0] fixed_value;
	// times known to be in the table, used to build remove and tick requests
	int known_times [$];

	day_schedule_event_table i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .hour(hour), .minute(minute), .entry_data(entry_data),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.out_hour(out_hour), .out_minute(out_minute), .out_data(out_data), .last(last)
	);

	always #5 clk = ~clk;

	function automatic int slot_minutes(int s);
		return sched_hour[s] * dset_pkg::MIN_PER_HOUR + sched_minute[s];
	endfunction

	function automatic int abs_diff(int a, int b);
		return a >= b ? a - b : b - a;
	endfunction

	function automatic int closest_slot(int t);
		int best;
		best = -1;
		for (int i = 0; i < dset_pkg::ENTRIES; i++)
			if (sched_used[i] && (best < 0 ||
					abs_diff(t, slot_minutes(i)) <= abs_diff(t, slot_minutes(best))))
				best = i;
		return best;
	endfunction

	function automatic void push_result(logic [2:0] st, logic [4:0] h, logic [5:0] m,
			logic [31:0] d, logic lst);
		result_t r;
		r.status = st;
		r.hour = h;
		r.minute = m;
		r.data = d;
		r.last = lst;
		expected_results.push_back(r);
	endfunction

	function automatic void clear_schedule();
		for (int i = 0; i < dset_pkg::ENTRIES; i++) begin
			sched_used[i] = 1'b0;
			sched_hour[i] = '0;
			sched_minute[i] = '0;
			sched_data[i] = '0;
			sched_next[i] = '0;
			sched_prev[i] = '0;
		end
		sched_count = 0;
		pend_valid = 1'b0;
		pend_slot = '0;
	endfunction

	// work out the results of one request and update the model
	function automatic void predict_schedule(logic [1:0] md, logic [4:0] h, logic [5:0] m,
			logic [31:0] d);
		int t, n, f, nb, p, hit, best;
		logic [2:0] st;
		logic [31:0] fired;
		logic taken [dset_pkg::ENTRIES];
		t = h * dset_pkg::MIN_PER_HOUR + m;
		st = dset_pkg::ST_OK;
		fired = '0;
		case (md)
			dset_pkg::MODE_TICK: begin
				if (sched_count == 0) begin
					st = dset_pkg::ST_EMPTY;
				end else if (!pend_valid) begin
					n = closest_slot(t);
					if (t >= slot_minutes(n)) begin
						fired = sched_data[n];
						pend_slot = sched_next[n];
					end else begin
						fired = sched_data[sched_prev[n]];
						pend_slot = 4'(n);
					end
					pend_valid = 1'b1;
				end else if (t == slot_minutes(pend_slot)) begin
					fired = sched_data[pend_slot];
					pend_slot = sched_next[pend_slot];
				end else begin
					st = dset_pkg::ST_EMPTY;
				end
				push_result(st, '0, '0, fired, 1'b1);
			end
			dset_pkg::MODE_ADD: begin
				if (sched_count >= dset_pkg::ENTRIES) begin
					st = dset_pkg::ST_OVERFLOW;
				end else begin
					f = 0;
					while (sched_used[f]) f++;
					n = closest_slot(t);
					if (n >= 0 && t == slot_minutes(n)) begin
						st = dset_pkg::ST_FAIL;
					end else begin
						if (n < 0) begin
							sched_next[f] = 4'(f);
							sched_prev[f] = 4'(f);
						end else if (t > slot_minutes(n)) begin
							nb = sched_next[n];
							sched_next[f] = 4'(nb);
							sched_prev[f] = 4'(n);
							sched_prev[nb] = 4'(f);
							sched_next[n] = 4'(f);
						end else begin
							nb = sched_prev[n];
							sched_next[f] = 4'(n);
							sched_prev[f] = 4'(nb);
							sched_next[nb] = 4'(f);
							sched_prev[n] = 4'(f);
						end
						sched_hour[f] = h;
						sched_minute[f] = m;
						sched_data[f] = d;
						sched_used[f] = 1'b1;
						sched_count++;
					end
				end
				push_result(st, '0, '0, '0, 1'b1);
			end
			dset_pkg::MODE_REMOVE: begin
				if (sched_count == 0) begin
					st = dset_pkg::ST_UNDERFLOW;
				end else begin
					hit = -1;
					for (int i = dset_pkg::ENTRIES - 1; i >= 0; i--)
						if (sched_used[i] && slot_minutes(i) == t) hit = i;
					if (hit < 0) begin
						st = dset_pkg::ST_FAIL;
					end else begin
						p = sched_prev[hit];
						nb = sched_next[hit];
						sched_next[p] = 4'(nb);
						sched_prev[nb] = 4'(p);
						sched_used[hit] = 1'b0;
						sched_count--;
						if (pend_valid && int'(pend_slot) == hit) pend_slot = 4'(nb);
						if (sched_count == 0) begin
							pend_valid = 1'b0;
							pend_slot = '0;
						end
					end
				end
				push_result(st, '0, '0, '0, 1'b1);
			end
			default: begin
				if (sched_count == 0) begin
					push_result(dset_pkg::ST_FAIL, '0, '0, '0, 1'b1);
				end else begin
					for (int i = 0; i < dset_pkg::ENTRIES; i++) taken[i] = 1'b0;
					for (int k = 0; k < sched_count; k++) begin
						best = -1;
						for (int i = 0; i < dset_pkg::ENTRIES; i++)
							if (sched_used[i] && !taken[i] &&
									(best < 0 || slot_minutes(i) < slot_minutes(best)))
								best = i;
						taken[best] = 1'b1;
						push_result(dset_pkg::ST_OK, sched_hour[best], sched_minute[best],
							sched_data[best], k == sched_count - 1);
					end
				end
			end
		endcase
	endfunction

	// drive one request, wait for its acceptance, then drop valid for a cycle
	task automatic send_request(logic [1:0] md, logic [4:0] h, logic [5:0] m, logic [31:0] d);
		mode <= md;
		hour <= h;
		minute <= m;
		entry_data <= d;
		in_valid <= 1'b1;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		predict_schedule(md, h, m, d);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall pattern, ready on most cycles
	always @(posedge clk) begin
		if ($urandom_range(0, 3) == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 255) < 160) ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	// compare accepted results with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $time, status, out_data);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (fixed_pending) begin
					if (status !== fixed_value) begin
						$display("%0t: table status expected %0d actual %0d", $time,
							fixed_value, status);
						errors++;
					end
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					errors++;
				end
				if (out_hour !== want.hour) begin
					$display("%0t: hour expected %0d actual %0d", $time, want.hour, out_hour);
					errors++;
				end
				if (out_minute !== want.minute) begin
					$display("%0t: minute expected %0d actual %0d", $time, want.minute,
						out_minute);
					errors++;
				end
				if (out_data !== want.data) begin
					$display("%0t: data expected %h actual %h", $time, want.data, out_data);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0d actual %0d", $time, want.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_day_schedule_event_table NOT OK");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		row_t stim_rows [$];
		row_t r;
		int burst, t, sel;
		logic [1:0] md;
		logic [4:0] h;
		logic [5:0] m;

		clear_schedule();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: mode, hour, minute, data, typed-in check, status
		stim_rows.push_back({dset_pkg::MODE_TICK, 5'd0, 6'd0, 32'd0, 1'b1,
			dset_pkg::ST_EMPTY});
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd1, 6'd0, 32'd0, 1'b1,
			dset_pkg::ST_UNDERFLOW});
		stim_rows.push_back({dset_pkg::MODE_LIST, 5'd0, 6'd0, 32'd0, 1'b1,
			dset_pkg::ST_FAIL});
		stim_rows.push_back({dset_pkg::MODE_ADD, 5'd0, 6'd0, 32'hFFFF_FFFF, 1'b1,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_ADD, 5'd31, 6'd63, 32'h0000_0000, 1'b1,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_ADD, 5'd0, 6'd0, 32'h1234_5678, 1'b1,
			dset_pkg::ST_FAIL});
		stim_rows.push_back({dset_pkg::MODE_ADD, 5'd12, 6'd0, 32'hA5A5_5A5A, 1'b0,
			dset_pkg::ST_OK});
		// entries on both sides of noon
		stim_rows.push_back({dset_pkg::MODE_ADD, 5'd11, 6'd0, 32'h0000_0011, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_ADD, 5'd13, 6'd0, 32'h0000_0013, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_LIST, 5'd0, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd5, 6'd5, 32'd0, 1'b1,
			dset_pkg::ST_FAIL});
		// first tick before the nearest entry, then a non-matching and a matching tick
		stim_rows.push_back({dset_pkg::MODE_TICK, 5'd10, 6'd59, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_TICK, 5'd10, 6'd0, 32'd0, 1'b1,
			dset_pkg::ST_EMPTY});
		stim_rows.push_back({dset_pkg::MODE_TICK, 5'd11, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		// remove the pending entry
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd12, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_TICK, 5'd13, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd0, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd31, 6'd63, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd11, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_REMOVE, 5'd13, 6'd0, 32'd0, 1'b0,
			dset_pkg::ST_OK});
		stim_rows.push_back({dset_pkg::MODE_LIST, 5'd0, 6'd0, 32'd0, 1'b1,
			dset_pkg::ST_FAIL});

		foreach (stim_rows[i]) begin
			r = stim_rows[i];
			if (r.fixed) begin
				// typed-in status is checked on the single result of this row
				wait_drained();
				fixed_value = r.fixed_status;
				fixed_pending = 1;
			end
			send_request(r.mode, r.hour, r.minute, r.data);
			if (r.fixed) begin
				wait_drained();
				fixed_pending = 0;
			end
		end
		wait_drained();

		// fill to capacity and overflow once
		for (int i = 0; i < dset_pkg::ENTRIES; i++)
			send_request(dset_pkg::MODE_ADD, 5'(i), 6'(i * 3), $urandom());
		send_request(dset_pkg::MODE_ADD, 5'd23, 6'd59, 32'hDEAD_BEEF);
		send_request(dset_pkg::MODE_LIST, 5'd0, 6'd0, 32'd0);
		for (int i = 0; i < dset_pkg::ENTRIES; i++)
			known_times.push_back(i * dset_pkg::MIN_PER_HOUR + i * 3);

		// random requests in bursts
		for (int n = 0; n < RANDOM_REQUESTS; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < RANDOM_REQUESTS; b++, n++) begin
				sel = $urandom_range(0, 99);
				h = 5'($urandom_range(0, 23));
				m = 6'($urandom_range(0, 59));
				if (sel < 5) begin
					h = 5'($urandom());
					m = 6'($urandom());
				end
				if (sel < 35) begin
					md = dset_pkg::MODE_ADD;
				end else if (sel < 60) begin
					md = dset_pkg::MODE_TICK;
					if (known_times.size() != 0 && sel < 52) begin
						t = known_times[$urandom_range(0, known_times.size() - 1)];
						h = 5'(t / dset_pkg::MIN_PER_HOUR);
						m = 6'(t % dset_pkg::MIN_PER_HOUR);
					end
				end else if (sel < 85) begin
					md = dset_pkg::MODE_REMOVE;
					if (known_times.size() != 0 && sel < 80) begin
						t = $urandom_range(0, known_times.size() - 1);
						h = 5'(known_times[t] / dset_pkg::MIN_PER_HOUR);
						m = 6'(known_times[t] % dset_pkg::MIN_PER_HOUR);
						known_times.delete(t);
					end
				end else begin
					md = dset_pkg::MODE_LIST;
				end
				if (md == dset_pkg::MODE_ADD)
					known_times.push_back(h * dset_pkg::MIN_PER_HOUR + m);
				send_request(md, h, m, rand_word());
			end
			// hold off until the table is quiet now and then
			if ($urandom_range(0, 7) == 0)
				wait_drained();
			else
				repeat ($urandom_range(0, 40)) @(posedge clk);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_day_schedule_event_table OK");
		else
			$display("tb_day_schedule_event_table NOT OK");
		$finish;
	end

endmodule
